@@ hdl/heightfield_triangle_height_query_assert.svh @@
// assertion macros for the terrain height query block
`ifndef HEIGHTFIELD_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTFIELD_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH

// same-cycle implication
`define HHQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HHQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/hhq_pkg.sv @@
// shared constants, types and helpers of the terrain height query block
`default_nettype none
package hhq_pkg;

   localparam int MAX_COLS    = 128;
   localparam int MAX_ROWS    = 128;
   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = 14;
   localparam int CNT_W       = 8;
   localparam int COORD_W     = 32;
   localparam int CELL_W      = 15;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;
   localparam int NRM_W       = PROD_W + 1;
   localparam int LO_W        = 34;
   localparam int HI_W        = NRM_W - LO_W;
   localparam int NUM_W       = NRM_W + DIFF_W + 1;
   localparam int QUO_W       = 33;
   localparam int REQ_DATA_W  = 176;
   localparam int RSP_DATA_W  = 40;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic CSR_COLS = 1'b0;
   localparam logic CSR_ROWS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_OUTSIDE = 2'd1,
      ST_DEGEN   = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } diff3_type;

   // accepted transaction, first pipeline stage
   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic [IDX_W-1:0]          widx;
      vertex_type                vtx;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qz;
   } item_type;

   // cell vertices read from the store
   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qz;
      vertex_type                v0;
      vertex_type                v1;
      vertex_type                v2;
      vertex_type                v3;
   } fetch_type;

   // operands handed to the divider
   typedef struct packed {
      logic                      vld;
      logic                      qry;
      status_type                status;
      logic                      neg;
      logic                      ovf;
      logic signed [COORD_W-1:0] y0;
      logic [NUM_W-1:0]          mn;
      logic [NRM_W-1:0]          md;
   } div_in_type;

   // divider result
   typedef struct packed {
      logic                      vld;
      logic                      qry;
      status_type                status;
      logic                      neg;
      logic                      ovf;
      logic signed [COORD_W-1:0] y0;
      logic [QUO_W-1:0]          qmag;
   } div_out_type;

   function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                       input logic signed [COORD_W-1:0] b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

   function automatic diff3_type vdiff(input vertex_type a, input vertex_type b);
      diff3_type d;
      d.x = sdiff(a.x, b.x);
      d.y = sdiff(a.y, b.y);
      d.z = sdiff(a.z, b.z);
      return d;
   endfunction

endpackage
`default_nettype wire

@@ hdl/hhq_fetch.sv @@
// cell lookup and replicated vertex store reads
`default_nettype none
module hhq_fetch (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic [hhq_pkg::CNT_W-1:0]    cols,
   input  logic [hhq_pkg::CNT_W-1:0]    rows,
   input  hhq_pkg::item_type            s1,
   output hhq_pkg::fetch_type           s3
);
   import hhq_pkg::*;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic                      we;
      logic [ADDR_W-1:0]         widx;
      vertex_type                wvtx;
      logic signed [COORD_W-1:0] qx;
      logic signed [COORD_W-1:0] qz;
   } addr_type;

   addr_type                   s2_in, s2_ff;
   logic [ADDR_W-1:0]          raddr_in [4];
   logic [ADDR_W-1:0]          raddr_ff [4];
   vertex_type                 rd_ff [4];
   logic                       s3_vld_ff, s3_qry_ff, s3_bad_ff;
   logic signed [COORD_W-1:0]  s3_qx_ff, s3_qz_ff;

   logic [CELL_W-1:0]          cx, cz;
   logic                       negx_bad, negz_bad, outx, outz, grid_small;
   logic [CELL_W+CNT_W-1:0]    rowbase;
   logic [ADDR_W-1:0]          a0, a2;

   always_comb begin
      // truncation toward zero: anything in (-1, 0) lands in cell 0
      cx = s1.qx[COORD_W-1] ? '0 : s1.qx[COORD_W-2:16];
      cz = s1.qz[COORD_W-1] ? '0 : s1.qz[COORD_W-2:16];
      negx_bad = s1.qx[COORD_W-1] && !(s1.qx[COORD_W-1:16] == 16'hFFFF && s1.qx[15:0] != 16'h0);
      negz_bad = s1.qz[COORD_W-1] && !(s1.qz[COORD_W-1:16] == 16'hFFFF && s1.qz[15:0] != 16'h0);
      grid_small = (cols < CNT_W'(2)) || (rows < CNT_W'(2));
      outx = ({1'b0, cx} + (CELL_W+1)'(1)) >= (CELL_W+1)'(cols);
      outz = ({1'b0, cz} + (CELL_W+1)'(1)) >= (CELL_W+1)'(rows);
      rowbase = cz * cols;
      a0 = ADDR_W'(rowbase + (CELL_W+CNT_W)'(cx));
      a2 = a0 + ADDR_W'(cols);

      s2_in.vld  = s1.vld;
      s2_in.qry  = s1.qry;
      s2_in.bad  = grid_small || negx_bad || negz_bad || outx || outz;
      s2_in.we   = s1.vld && (s1.qry == REQ_WRITE)
                   && ({1'b0, s1.widx} < (IDX_W+1)'(STORE_DEPTH));
      s2_in.widx = ADDR_W'(s1.widx);
      s2_in.wvtx = s1.vtx;
      s2_in.qx   = s1.qx;
      s2_in.qz   = s1.qz;

      raddr_in[0] = a0;
      raddr_in[1] = a0 + ADDR_W'(1);
      raddr_in[2] = a2;
      raddr_in[3] = a2 + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end else if (en) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raddr_ff <= raddr_in;
      end
   end

   // one copy of the store per read port, all written alike
   for (genvar g = 0; g < 4; g++) begin : g_copy
      vertex_type mem [STORE_DEPTH];
      always_ff @(posedge clock) begin
         if (en) begin
            if (s2_ff.vld && s2_ff.we) begin
               mem[s2_ff.widx] <= s2_ff.wvtx;
            end
            rd_ff[g] <= mem[raddr_ff[g]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_qry_ff <= s2_ff.qry;
         s3_bad_ff <= s2_ff.bad;
         s3_qx_ff  <= s2_ff.qx;
         s3_qz_ff  <= s2_ff.qz;
      end
   end

   assign s3.vld = s3_vld_ff;
   assign s3.qry = s3_qry_ff;
   assign s3.bad = s3_bad_ff;
   assign s3.qx  = s3_qx_ff;
   assign s3.qz  = s3_qz_ff;
   assign s3.v0  = rd_ff[0];
   assign s3.v1  = rd_ff[1];
   assign s3.v2  = rd_ff[2];
   assign s3.v3  = rd_ff[3];

endmodule
`default_nettype wire

@@ hdl/hhq_plane.sv @@
// triangle choice, plane normal and numerator of the height formula
`default_nettype none
module hhq_plane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  hhq_pkg::fetch_type    s3,
   output hhq_pkg::div_in_type   dq
);
   import hhq_pkg::*;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic signed [COORD_W-1:0] y0;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dz;
      diff3_type                 da;
      diff3_type                 db;
      diff3_type                 d2;
   } p4_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic signed [COORD_W-1:0] y0;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dz;
      diff3_type                 d1;
      diff3_type                 d2;
   } p5_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic signed [COORD_W-1:0] y0;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dz;
      logic signed [PROD_W-1:0]  m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;
   } p6_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic signed [COORD_W-1:0] y0;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dz;
      logic signed [NRM_W-1:0]   nx, ny, nz;
   } p7_type;

   typedef struct packed {
      logic                              vld;
      logic                              qry;
      logic                              bad;
      logic                              degen;
      logic signed [COORD_W-1:0]         y0;
      logic signed [NRM_W-1:0]           ny;
      logic signed [HI_W+DIFF_W-1:0]     hx, hz;
      logic signed [LO_W+DIFF_W:0]       lx, lz;
   } p8_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic                      degen;
      logic signed [COORD_W-1:0] y0;
      logic signed [NRM_W-1:0]   ny;
      logic signed [NUM_W-1:0]   px, pz;
   } p9_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      logic                      bad;
      logic                      degen;
      logic signed [COORD_W-1:0] y0;
      logic signed [NRM_W-1:0]   ny;
      logic signed [NUM_W-1:0]   num;
   } p10_type;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      status_type                status;
      logic                      neg;
      logic signed [COORD_W-1:0] y0;
      logic [NUM_W-1:0]          mn;
      logic [NRM_W-1:0]          md;
   } p11_type;

   p4_type     p4_in,  p4_ff;
   p5_type     p5_in,  p5_ff;
   p6_type     p6_in,  p6_ff;
   p7_type     p7_in,  p7_ff;
   p8_type     p8_in,  p8_ff;
   p9_type     p9_in,  p9_ff;
   p10_type    p10_in, p10_ff;
   p11_type    p11_in, p11_ff;
   div_in_type p12_in, p12_ff;

   always_comb begin
      p4_in.vld = s3.vld;
      p4_in.qry = s3.qry;
      p4_in.bad = s3.bad;
      p4_in.y0  = s3.v0.y;
      p4_in.dx  = sdiff(s3.qx, s3.v0.x);
      p4_in.dz  = sdiff(s3.qz, s3.v0.z);
      p4_in.da  = vdiff(s3.v1, s3.v0);
      p4_in.db  = vdiff(s3.v2, s3.v0);
      p4_in.d2  = vdiff(s3.v3, s3.v0);
   end

   always_comb begin
      p5_in.vld = p4_ff.vld;
      p5_in.qry = p4_ff.qry;
      p5_in.bad = p4_ff.bad;
      p5_in.y0  = p4_ff.y0;
      p5_in.dx  = p4_ff.dx;
      p5_in.dz  = p4_ff.dz;
      // upper triangle along x when the query sits right of the diagonal
      p5_in.d1  = ($signed(p4_ff.dx) > $signed(p4_ff.dz)) ? p4_ff.da : p4_ff.db;
      p5_in.d2  = p4_ff.d2;
   end

   always_comb begin
      p6_in.vld  = p5_ff.vld;
      p6_in.qry  = p5_ff.qry;
      p6_in.bad  = p5_ff.bad;
      p6_in.y0   = p5_ff.y0;
      p6_in.dx   = p5_ff.dx;
      p6_in.dz   = p5_ff.dz;
      p6_in.m_yz = $signed(p5_ff.d1.y) * $signed(p5_ff.d2.z);
      p6_in.m_zy = $signed(p5_ff.d1.z) * $signed(p5_ff.d2.y);
      p6_in.m_zx = $signed(p5_ff.d1.z) * $signed(p5_ff.d2.x);
      p6_in.m_xz = $signed(p5_ff.d1.x) * $signed(p5_ff.d2.z);
      p6_in.m_xy = $signed(p5_ff.d1.x) * $signed(p5_ff.d2.y);
      p6_in.m_yx = $signed(p5_ff.d1.y) * $signed(p5_ff.d2.x);
   end

   always_comb begin
      p7_in.vld = p6_ff.vld;
      p7_in.qry = p6_ff.qry;
      p7_in.bad = p6_ff.bad;
      p7_in.y0  = p6_ff.y0;
      p7_in.dx  = p6_ff.dx;
      p7_in.dz  = p6_ff.dz;
      p7_in.nx  = NRM_W'($signed(p6_ff.m_yz)) - NRM_W'($signed(p6_ff.m_zy));
      p7_in.ny  = NRM_W'($signed(p6_ff.m_zx)) - NRM_W'($signed(p6_ff.m_xz));
      p7_in.nz  = NRM_W'($signed(p6_ff.m_xy)) - NRM_W'($signed(p6_ff.m_yx));
   end

   // x and z normal components split into a signed high and an unsigned low part
   always_comb begin
      p8_in.vld   = p7_ff.vld;
      p8_in.qry   = p7_ff.qry;
      p8_in.bad   = p7_ff.bad;
      p8_in.degen = (p7_ff.ny == '0);
      p8_in.y0    = p7_ff.y0;
      p8_in.ny    = p7_ff.ny;
      p8_in.hx    = $signed(p7_ff.nx[NRM_W-1:LO_W]) * $signed(p7_ff.dx);
      p8_in.hz    = $signed(p7_ff.nz[NRM_W-1:LO_W]) * $signed(p7_ff.dz);
      p8_in.lx    = $signed({1'b0, p7_ff.nx[LO_W-1:0]}) * $signed(p7_ff.dx);
      p8_in.lz    = $signed({1'b0, p7_ff.nz[LO_W-1:0]}) * $signed(p7_ff.dz);
   end

   always_comb begin
      p9_in.vld   = p8_ff.vld;
      p9_in.qry   = p8_ff.qry;
      p9_in.bad   = p8_ff.bad;
      p9_in.degen = p8_ff.degen;
      p9_in.y0    = p8_ff.y0;
      p9_in.ny    = p8_ff.ny;
      p9_in.px    = (NUM_W'($signed(p8_ff.hx)) <<< LO_W) + NUM_W'($signed(p8_ff.lx));
      p9_in.pz    = (NUM_W'($signed(p8_ff.hz)) <<< LO_W) + NUM_W'($signed(p8_ff.lz));
   end

   always_comb begin
      p10_in.vld   = p9_ff.vld;
      p10_in.qry   = p9_ff.qry;
      p10_in.bad   = p9_ff.bad;
      p10_in.degen = p9_ff.degen;
      p10_in.y0    = p9_ff.y0;
      p10_in.ny    = p9_ff.ny;
      p10_in.num   = p9_ff.px + p9_ff.pz;
   end

   always_comb begin
      p11_in.vld = p10_ff.vld;
      p11_in.qry = p10_ff.qry;
      priority if (p10_ff.bad) begin
         p11_in.status = ST_OUTSIDE;
      end else if (p10_ff.degen) begin
         p11_in.status = ST_DEGEN;
      end else begin
         p11_in.status = ST_OK;
      end
      p11_in.neg = p10_ff.num[NUM_W-1] ^ p10_ff.ny[NRM_W-1];
      p11_in.y0  = p10_ff.y0;
      p11_in.mn  = p10_ff.num[NUM_W-1] ? NUM_W'(-p10_ff.num) : NUM_W'(p10_ff.num);
      p11_in.md  = p10_ff.ny[NRM_W-1] ? NRM_W'(-p10_ff.ny) : NRM_W'(p10_ff.ny);
   end

   // quotient too large for the divider stages means the height saturates
   always_comb begin
      p12_in.vld    = p11_ff.vld;
      p12_in.qry    = p11_ff.qry;
      p12_in.status = p11_ff.status;
      p12_in.neg    = p11_ff.neg;
      p12_in.y0     = p11_ff.y0;
      p12_in.mn     = p11_ff.mn;
      p12_in.md     = p11_ff.md;
      p12_in.ovf    = p11_ff.mn >= (NUM_W'(p11_ff.md) << QUO_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_ff.vld  <= 1'b0;
         p5_ff.vld  <= 1'b0;
         p6_ff.vld  <= 1'b0;
         p7_ff.vld  <= 1'b0;
         p8_ff.vld  <= 1'b0;
         p9_ff.vld  <= 1'b0;
         p10_ff.vld <= 1'b0;
         p11_ff.vld <= 1'b0;
         p12_ff.vld <= 1'b0;
      end else if (en) begin
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         p6_ff  <= p6_in;
         p7_ff  <= p7_in;
         p8_ff  <= p8_in;
         p9_ff  <= p9_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         p12_ff <= p12_in;
      end
   end

   assign dq = p12_ff;

endmodule
`default_nettype wire

@@ hdl/hhq_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module hhq_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  hhq_pkg::div_in_type   dq,
   output hhq_pkg::div_out_type  qo
);
   import hhq_pkg::*;

   typedef struct packed {
      logic                      vld;
      logic                      qry;
      status_type                status;
      logic                      neg;
      logic                      ovf;
      logic signed [COORD_W-1:0] y0;
      logic [QUO_W-1:0]          q;
      logic [NUM_W-1:0]          r;
      logic [NRM_W-1:0]          md;
   } dstage_type;

   dstage_type head;
   dstage_type stg_in [QUO_W];
   dstage_type stg_ff [QUO_W];

   always_comb begin
      head.vld    = dq.vld;
      head.qry    = dq.qry;
      head.status = dq.status;
      head.neg    = dq.neg;
      head.ovf    = dq.ovf;
      head.y0     = dq.y0;
      head.q      = '0;
      head.r      = dq.mn;
      head.md     = dq.md;
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_stage
      localparam int K = QUO_W - 1 - g;
      dstage_type       prev;
      logic [NUM_W-1:0] trial;

      if (g == 0) begin : g_first
         assign prev = head;
      end else begin : g_next
         assign prev = stg_ff[g-1];
      end

      always_comb begin
         trial     = NUM_W'(prev.md) << K;
         stg_in[g] = prev;
         if (prev.r >= trial) begin
            stg_in[g].r    = prev.r - trial;
            stg_in[g].q[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[g].vld <= 1'b0;
         end else if (en) begin
            stg_ff[g] <= stg_in[g];
         end
      end
   end

   assign qo.vld    = stg_ff[QUO_W-1].vld;
   assign qo.qry    = stg_ff[QUO_W-1].qry;
   assign qo.status = stg_ff[QUO_W-1].status;
   assign qo.neg    = stg_ff[QUO_W-1].neg;
   assign qo.ovf    = stg_ff[QUO_W-1].ovf;
   assign qo.y0     = stg_ff[QUO_W-1].y0;
   assign qo.qmag   = stg_ff[QUO_W-1].q;

endmodule
`default_nettype wire

@@ hdl/heightfield_triangle_height_query.sv @@
// Terrain height query: keeps a grid of vertices written by write transactions and returns,
// for each query transaction, the height of the cell triangle's plane at (x, z) in Q16.16
// with a status. Write transactions give no response. One transaction enters per cycle
// unless the pipeline stalls; a query passes through the input register, address calculation
// and store read, the plane arithmetic, the divider (one quotient bit per stage) and the
// output register. The pipeline stalls only when a finished response meets a full,
// unaccepted output register.
`default_nettype none
module heightfield_triangle_height_query (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vertex_index, vertex_x, vertex_y, vertex_z, query_x, query_z, zero pad
   input  logic [hhq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // height, status, zero pad
   output logic [hhq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [hhq_pkg::CNT_W-1:0]          csr_wdata
);
   import hhq_pkg::*;
`include "heightfield_triangle_height_query_assert.svh"

   logic [CNT_W-1:0]          grid_cols_ff, grid_rows_ff;
   logic [CNT_W-1:0]          cols, rows;
   logic                      en, rsp_load;
   item_type                  s1_in, s1_ff;
   fetch_type                 s3;
   div_in_type                dq;
   div_out_type               qo;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_height_ff, rsp_height_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [COORD_W+2:0] hsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= '0;
         grid_rows_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLS: grid_cols_ff <= csr_wdata;
            CSR_ROWS: grid_rows_ff <= csr_wdata;
         endcase
      end
   end

   assign cols = (int'(grid_cols_ff) > MAX_COLS) ? CNT_W'(MAX_COLS) : grid_cols_ff;
   assign rows = (int'(grid_rows_ff) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : grid_rows_ff;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign en         = !(qo.vld && qo.qry) || rsp_load;
   assign req_tready = en;

   always_comb begin
      s1_in.vld   = req_tvalid;
      s1_in.qry   = req_tuser;
      s1_in.widx  = req_tdata[13:0];
      s1_in.vtx.x = req_tdata[45:14];
      s1_in.vtx.y = req_tdata[77:46];
      s1_in.vtx.z = req_tdata[109:78];
      s1_in.qx    = req_tdata[141:110];
      s1_in.qz    = req_tdata[173:142];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   hhq_fetch u_fetch (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .cols  (cols),
      .rows  (rows),
      .s1    (s1_ff),
      .s3    (s3)
   );

   hhq_plane u_plane (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .s3    (s3),
      .dq    (dq)
   );

   hhq_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .dq    (dq),
      .qo    (qo)
   );

   // height = y0 - quotient, saturated
   always_comb begin
      hsum = qo.neg ? ((COORD_W+3)'(qo.y0) + $signed((COORD_W+3)'(qo.qmag)))
                    : ((COORD_W+3)'(qo.y0) - $signed((COORD_W+3)'(qo.qmag)));
      rsp_valid_in  = qo.vld && qo.qry;
      rsp_status_in = qo.status;
      priority if (qo.status != ST_OK) begin
         rsp_height_in = '0;
      end else if (qo.ovf) begin
         rsp_height_in = qo.neg ? {1'b0, {(COORD_W-1){1'b1}}} : {1'b1, {(COORD_W-1){1'b0}}};
      end else if (hsum > $signed({3'b000, 1'b0, {(COORD_W-1){1'b1}}})) begin
         rsp_height_in = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (hsum < $signed({3'b111, 1'b1, {(COORD_W-1){1'b0}}})) begin
         rsp_height_in = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         rsp_height_in = hsum[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_height_ff <= rsp_height_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-COORD_W-2){1'b0}}, rsp_status_ff, rsp_height_ff};

   `HHQ_ASSERT_NEXT(a_result_lands, clock, reset, qo.vld && qo.qry && rsp_load, rsp_valid_ff, "finished query did not reach the output register")
   `HHQ_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(s1_ff), "input stage changed during a stall")
   `HHQ_ASSERT_NOW(a_zero_on_error, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_height_ff == '0, "nonzero height with error status")

endmodule
`default_nettype wire
